// File: hw/rtl/gost_block_cipher_ecb_macros.svh
// ----------------------------------------------------------------------------
// GOST block cipher assertion macros
// Clocked assertion forms shared by the checker.
// ----------------------------------------------------------------------------
`ifndef GOST_BLOCK_CIPHER_ECB_MACROS_SVH
`define GOST_BLOCK_CIPHER_ECB_MACROS_SVH

// clocked, disabled during reset
`define GBC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked, active during reset
`define GBC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/gbc_pkg.sv
// ----------------------------------------------------------------------------
// GOST block cipher package
// Types, S-box table and round function of the GOST 28147-89 cipher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gbc_pkg;

  localparam int ROUNDS      = 32;
  localparam int KEY_WORDS   = 8;
  localparam int WORD_W      = 32;
  localparam int KEY_IDX_W   = 4;
  localparam int SUBKEY_W    = 3;
  localparam int ROT_LEFT    = 11;

  typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_array_t;

  typedef struct packed {
    logic              valid;
    logic              mode;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } stage_t;

  typedef logic [3:0] sbox_t [8][16];

  localparam sbox_t SBOX = '{
    '{4'h9, 4'h6, 4'h3, 4'h2, 4'h8, 4'hB, 4'h1, 4'h7,
      4'hA, 4'h4, 4'hE, 4'hF, 4'hC, 4'h0, 4'hD, 4'h5},
    '{4'h3, 4'h7, 4'hE, 4'h9, 4'h8, 4'hA, 4'hF, 4'h0,
      4'h5, 4'h2, 4'h6, 4'hC, 4'hB, 4'h4, 4'hD, 4'h1},
    '{4'hE, 4'h4, 4'h6, 4'h2, 4'hB, 4'h3, 4'hD, 4'h8,
      4'hC, 4'hF, 4'h5, 4'hA, 4'h0, 4'h7, 4'h1, 4'h9},
    '{4'hE, 4'h7, 4'hA, 4'hC, 4'hD, 4'h1, 4'h3, 4'h9,
      4'h0, 4'h2, 4'hB, 4'h4, 4'hF, 4'h8, 4'h5, 4'h6},
    '{4'hB, 4'h5, 4'h1, 4'h9, 4'h8, 4'hD, 4'hF, 4'h0,
      4'hE, 4'h4, 4'h2, 4'h3, 4'hC, 4'h7, 4'hA, 4'h6},
    '{4'h3, 4'hA, 4'hD, 4'hC, 4'h1, 4'h2, 4'h0, 4'hB,
      4'h7, 4'h5, 4'h9, 4'h4, 4'h8, 4'hF, 4'hE, 4'h6},
    '{4'h1, 4'hD, 4'h2, 4'h9, 4'h7, 4'hA, 4'h6, 4'h0,
      4'h8, 4'hC, 4'h4, 4'h5, 4'hF, 4'h3, 4'hB, 4'hE},
    '{4'hB, 4'hA, 4'hF, 4'h5, 4'h0, 4'hC, 4'hE, 4'h8,
      4'h6, 4'h2, 4'h3, 4'h9, 4'h1, 4'h7, 4'hD, 4'h4}
  };

  function automatic logic [SUBKEY_W-1:0] subkey_index(input int r, input int rounds,
                                                       input logic decrypt);
    logic [SUBKEY_W-1:0] pos;
    logic                fwd;
    pos = SUBKEY_W'(r);
    fwd = decrypt ? (r < KEY_WORDS) : (r < rounds - KEY_WORDS);
    return fwd ? pos : ~pos;
  endfunction

  function automatic logic [WORD_W-1:0] round_fn(input logic [WORD_W-1:0] sum);
    logic [WORD_W-1:0] subst;
    for (int n = 0; n < 8; n++) begin
      subst[4*n +: 4] = SBOX[n][sum[4*n +: 4]];
    end
    return {subst[WORD_W-ROT_LEFT-1:0], subst[WORD_W-1:WORD_W-ROT_LEFT]};
  endfunction

endpackage

// File: hw/rtl/gost_block_cipher_ecb.sv
// ----------------------------------------------------------------------------
// GOST 28147-89 block cipher, ECB
// Fully pipelined engine, one Feistel round per register stage.
// ----------------------------------------------------------------------------
// channel   ports                          transaction
// input     start, busy, mode, data_block  start && !busy
// result    done, result_block             done (one cycle, no hold-off)
// config    wr_en, wr_index, wr_data       wr_en
//
// The result is registered once in each stage of the chain of round stages.
// A new block may enter every cycle; busy stays low.
// Synchronous reset clears the stage valid bits and the key to zero.
// The pipeline never stalls: each stage advances every cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gost_block_cipher_ecb #(
  parameter int ROUNDS = gbc_pkg::ROUNDS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          mode,
  input  logic [2*gbc_pkg::WORD_W-1:0]  data_block,
  output logic                          done,
  output logic [2*gbc_pkg::WORD_W-1:0]  result_block,
  input  logic                          wr_en,
  input  logic [gbc_pkg::KEY_IDX_W-1:0] wr_index,
  input  logic [gbc_pkg::WORD_W-1:0]    wr_data
);

  gbc_pkg::key_array_t keys;
  gbc_pkg::stage_t     chain [ROUNDS+1];

  gbc_keys u_keys (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .keys     (keys)
  );

  assign busy = 1'b0;

  assign chain[0] = '{valid: start && !busy,
                      mode:  mode,
                      a:     data_block[2*gbc_pkg::WORD_W-1:gbc_pkg::WORD_W],
                      b:     data_block[gbc_pkg::WORD_W-1:0]};

  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    gbc_round #(
      .ROUND  (r),
      .ROUNDS (ROUNDS)
    ) u_round (
      .clk  (clk),
      .rst  (rst),
      .keys (keys),
      .d    (chain[r]),
      .q    (chain[r+1])
    );
  end

  // drop the exchange of the final round
  assign done         = chain[ROUNDS].valid;
  assign result_block = {chain[ROUNDS].b, chain[ROUNDS].a};

endmodule

// File: hw/rtl/gbc_keys.sv
// ----------------------------------------------------------------------------
// GOST block cipher key file
// Eight 32-bit subkey registers written through the configuration port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gbc_keys (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [gbc_pkg::KEY_IDX_W-1:0] wr_index,
  input  logic [gbc_pkg::WORD_W-1:0]    wr_data,
  output gbc_pkg::key_array_t           keys
);

  always_ff @(posedge clk) begin
    if (rst) begin
      keys <= '0;
    end else if (wr_en && !wr_index[gbc_pkg::KEY_IDX_W-1]) begin
      keys[wr_index[gbc_pkg::SUBKEY_W-1:0]] <= wr_data;
    end
  end

endmodule

// File: hw/rtl/gbc_round.sv
// ----------------------------------------------------------------------------
// GOST block cipher round stage
// One registered Feistel round with its subkey chosen by direction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gbc_round #(
  parameter int ROUND  = 0,
  parameter int ROUNDS = gbc_pkg::ROUNDS
) (
  input  logic                clk,
  input  logic                rst,
  input  gbc_pkg::key_array_t keys,
  input  gbc_pkg::stage_t     d,
  output gbc_pkg::stage_t     q
);

  localparam logic [gbc_pkg::SUBKEY_W-1:0] ENC_IDX = gbc_pkg::subkey_index(ROUND, ROUNDS, 1'b0);
  localparam logic [gbc_pkg::SUBKEY_W-1:0] DEC_IDX = gbc_pkg::subkey_index(ROUND, ROUNDS, 1'b1);

  logic [gbc_pkg::WORD_W-1:0] subkey;
  logic [gbc_pkg::WORD_W-1:0] sum;
  logic [gbc_pkg::WORD_W-1:0] a_next;

  always_comb begin
    subkey = d.mode ? keys[DEC_IDX] : keys[ENC_IDX];
    sum    = d.a + subkey;
    a_next = d.b ^ gbc_pkg::round_fn(sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else begin
      q.valid <= d.valid;
    end
    q.mode <= d.mode;
    q.a    <= a_next;
    q.b    <= d.a;
  end

endmodule

// File: hw/rtl/gbc_checker.sv
// ----------------------------------------------------------------------------
// GOST block cipher port checker
// Latency and reset behaviour seen at the top-level ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gost_block_cipher_ecb_macros.svh"

module gbc_checker #(
  parameter int ROUNDS = gbc_pkg::ROUNDS
) (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  `GBC_ASSERT(a_result_follows, clk, rst, (start && !busy) |-> ##ROUNDS done, "result missing")
  `GBC_ASSERT(a_result_has_cause, clk, rst, done |-> $past(start && !busy, ROUNDS), "result invented")
  `GBC_ASSERT_ALWAYS(a_reset_flush, clk, rst |=> !done, "result after reset")

endmodule

bind gost_block_cipher_ecb gbc_checker #(
  .ROUNDS (ROUNDS)
) u_gbc_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// GOST 28147-89 ECB cipher testbench
// Drives blocks through the pipelined engine under several keys, with the
// sender idling at varied rates. A behavioural cipher computes each expected
// block when its transaction is accepted; results are checked in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int BLK_W        = 2 * gbc_pkg::WORD_W;
  localparam int IDX_W        = gbc_pkg::KEY_IDX_W;
  localparam int QUIET_LIMIT  = 1000;
  localparam int RANDOM_ITEMS = 400;

  localparam logic DIR_ENCRYPT = 1'b0;
  localparam logic DIR_DECRYPT = 1'b1;

  localparam logic [gbc_pkg::KEY_IDX_W-1:0] KEY_WORD_0    = 4'd0;
  localparam logic [gbc_pkg::KEY_IDX_W-1:0] KEY_WORD_LAST = 4'd7;
  localparam logic [gbc_pkg::KEY_IDX_W-1:0] KEY_IDX_TOP   = 4'd15;

  localparam logic [3:0] SUBST_ROWS [8][16] = '{
    '{4'h9, 4'h6, 4'h3, 4'h2, 4'h8, 4'hB, 4'h1, 4'h7,
      4'hA, 4'h4, 4'hE, 4'hF, 4'hC, 4'h0, 4'hD, 4'h5},
    '{4'h3, 4'h7, 4'hE, 4'h9, 4'h8, 4'hA, 4'hF, 4'h0,
      4'h5, 4'h2, 4'h6, 4'hC, 4'hB, 4'h4, 4'hD, 4'h1},
    '{4'hE, 4'h4, 4'h6, 4'h2, 4'hB, 4'h3, 4'hD, 4'h8,
      4'hC, 4'hF, 4'h5, 4'hA, 4'h0, 4'h7, 4'h1, 4'h9},
    '{4'hE, 4'h7, 4'hA, 4'hC, 4'hD, 4'h1, 4'h3, 4'h9,
      4'h0, 4'h2, 4'hB, 4'h4, 4'hF, 4'h8, 4'h5, 4'h6},
    '{4'hB, 4'h5, 4'h1, 4'h9, 4'h8, 4'hD, 4'hF, 4'h0,
      4'hE, 4'h4, 4'h2, 4'h3, 4'hC, 4'h7, 4'hA, 4'h6},
    '{4'h3, 4'hA, 4'hD, 4'hC, 4'h1, 4'h2, 4'h0, 4'hB,
      4'h7, 4'h5, 4'h9, 4'h4, 4'h8, 4'hF, 4'hE, 4'h6},
    '{4'h1, 4'hD, 4'h2, 4'h9, 4'h7, 4'hA, 4'h6, 4'h0,
      4'h8, 4'hC, 4'h4, 4'h5, 4'hF, 4'h3, 4'hB, 4'hE},
    '{4'hB, 4'hA, 4'hF, 4'h5, 4'h0, 4'hC, 4'hE, 4'h8,
      4'h6, 4'h2, 4'h3, 4'h9, 4'h1, 4'h7, 4'hD, 4'h4}
  };

  typedef enum logic [1:0] {
    JOB_BLOCK,
    JOB_KEY_WRITE,
    JOB_DRAIN,
    JOB_IDLE_RATE
  } job_kind_e;

  typedef struct {
    job_kind_e                      kind;
    logic                           dir;
    logic [BLK_W-1:0]               blk;
    logic [gbc_pkg::KEY_IDX_W-1:0]  idx;
    logic [gbc_pkg::WORD_W-1:0]     val;
    int                             rate;
  } cipher_job_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic                          busy;
  logic                          mode = DIR_ENCRYPT;
  logic [BLK_W-1:0]              data_block = '0;
  logic                          done;
  logic [BLK_W-1:0]              result_block;
  logic                          wr_en = 1'b0;
  logic [gbc_pkg::KEY_IDX_W-1:0] wr_index = KEY_WORD_0;
  logic [gbc_pkg::WORD_W-1:0]    wr_data = '0;

  cipher_job_t                   cipher_jobs[$];
  logic [BLK_W-1:0]              predicted_blocks[$];
  logic [gbc_pkg::WORD_W-1:0]    key_shadow [8];
  logic                          taken = 1'b0;
  logic                          jobs_finished = 1'b0;
  int                            idle_rate = 0;
  int                            quiet_cycles = 0;
  int                            errors = 0;

  gost_block_cipher_ecb DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .data_block   (data_block),
    .done         (done),
    .result_block (result_block),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data)
  );

  always #5 clk = ~clk;

  function automatic logic [BLK_W-1:0] gost_transform(input logic dir,
                                                      input logic [BLK_W-1:0] blk);
    logic [gbc_pkg::WORD_W-1:0] a;
    logic [gbc_pkg::WORD_W-1:0] b;
    logic [gbc_pkg::WORD_W-1:0] sum;
    logic [gbc_pkg::WORD_W-1:0] sub;
    logic [gbc_pkg::WORD_W-1:0] hold;
    int                         pos;
    int                         sel;
    a = blk[BLK_W-1:gbc_pkg::WORD_W];
    b = blk[gbc_pkg::WORD_W-1:0];
    for (int r = 0; r < gbc_pkg::ROUNDS; r++) begin
      pos = r % 8;
      if (dir == DIR_DECRYPT)
        sel = (r < 8) ? pos : 7 - pos;
      else
        sel = (r < gbc_pkg::ROUNDS - 8) ? pos : 7 - pos;
      sum = a + key_shadow[sel];
      for (int n = 0; n < 8; n++)
        sub[4*n +: 4] = SUBST_ROWS[n][sum[4*n +: 4]];
      hold = a;
      a = b ^ {sub[20:0], sub[31:21]};
      b = hold;
    end
    return {b, a};
  endfunction

  task automatic push_block(input logic dir, input logic [BLK_W-1:0] blk);
    cipher_job_t j;
    j = '{kind: JOB_BLOCK, dir: dir, blk: blk, idx: KEY_WORD_0, val: '0, rate: 0};
    cipher_jobs.push_back(j);
  endtask

  task automatic push_key_write(input logic [gbc_pkg::KEY_IDX_W-1:0] idx,
                                input logic [gbc_pkg::WORD_W-1:0] val);
    cipher_job_t j;
    j = '{kind: JOB_KEY_WRITE, dir: DIR_ENCRYPT, blk: '0, idx: idx, val: val, rate: 0};
    cipher_jobs.push_back(j);
  endtask

  task automatic push_control(input job_kind_e kind, input int rate);
    cipher_job_t j;
    j = '{kind: kind, dir: DIR_ENCRYPT, blk: '0, idx: KEY_WORD_0, val: '0, rate: rate};
    cipher_jobs.push_back(j);
  endtask

  task automatic program_key(input logic [7:0][gbc_pkg::WORD_W-1:0] words);
    for (int i = 0; i < 8; i++)
      push_key_write(KEY_WORD_0 + IDX_W'(i), words[i]);
  endtask

  // driver: present jobs at the falling edge
  always @(negedge clk) begin : drive
    logic                          n_start;
    logic                          n_mode;
    logic [BLK_W-1:0]              n_blk;
    logic                          n_wr;
    logic [gbc_pkg::KEY_IDX_W-1:0] n_idx;
    logic [gbc_pkg::WORD_W-1:0]    n_val;
    n_start = start;
    n_mode  = mode;
    n_blk   = data_block;
    n_wr    = 1'b0;
    n_idx   = wr_index;
    n_val   = wr_data;
    if (rst) begin
      n_start = 1'b0;
    end else if (!start || taken) begin
      n_start = 1'b0;
      if (cipher_jobs.size() != 0) begin
        case (cipher_jobs[0].kind)
          JOB_IDLE_RATE: begin
            idle_rate = cipher_jobs[0].rate;
            void'(cipher_jobs.pop_front());
          end
          JOB_DRAIN: begin
            if (predicted_blocks.size() == 0)
              void'(cipher_jobs.pop_front());
          end
          JOB_KEY_WRITE: begin
            if (predicted_blocks.size() == 0) begin
              n_wr  = 1'b1;
              n_idx = cipher_jobs[0].idx;
              n_val = cipher_jobs[0].val;
              if (n_idx <= KEY_WORD_LAST)
                key_shadow[n_idx[2:0]] = n_val;
              void'(cipher_jobs.pop_front());
            end
          end
          default: begin
            if ($urandom_range(99) >= idle_rate) begin
              n_start = 1'b1;
              n_mode  = cipher_jobs[0].dir;
              n_blk   = cipher_jobs[0].blk;
              void'(cipher_jobs.pop_front());
            end
          end
        endcase
      end
    end
    start         <= n_start;
    mode          <= n_mode;
    data_block    <= n_blk;
    wr_en         <= n_wr;
    wr_index      <= n_idx;
    wr_data       <= n_val;
    jobs_finished <= !rst && cipher_jobs.size() == 0 && !n_start;
  end

  // monitor: predict on acceptance, check each result against the oldest prediction
  always @(posedge clk) begin : observe
    logic [BLK_W-1:0] want;
    if (rst) begin
      taken        <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      taken <= start && !busy;
      if (start && !busy)
        predicted_blocks.push_back(gost_transform(mode, data_block));
      if (done) begin
        if (predicted_blocks.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual %h",
                   $time, result_block);
          errors++;
        end else begin
          want = predicted_blocks.pop_front();
          if (result_block !== want) begin
            $display("%0t ns: result_block mismatch, expected %h, actual %h",
                     $time, want, result_block);
            errors++;
          end
        end
      end
      if ((start && !busy) || done || wr_en) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t ns: watchdog expired with %0d results outstanding",
                 $time, predicted_blocks.size());
        $display("*** FAILED ***");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    logic [7:0][gbc_pkg::WORD_W-1:0] key_words;
    logic [BLK_W-1:0]                blk;
    int                              bit_pos;
    for (int i = 0; i < 8; i++)
      key_shadow[i] = '0;

    // all-zero key after reset
    push_control(JOB_IDLE_RATE, 22);
    push_block(DIR_ENCRYPT, '0);
    push_block(DIR_ENCRYPT, '1);
    push_block(DIR_DECRYPT, '0);
    push_block(DIR_DECRYPT, '1);
    // writes beyond the last key word leave the key alone
    push_key_write(IDX_W'(KEY_WORD_LAST + 1), '1);
    push_key_write(KEY_IDX_TOP, '1);
    push_block(DIR_ENCRYPT, '0);
    push_block(DIR_DECRYPT, {32{2'b01}});
    program_key({8{32'hFFFF_FFFF}});
    push_block(DIR_ENCRYPT, '0);
    push_block(DIR_ENCRYPT, '1);
    push_block(DIR_DECRYPT, '0);
    push_block(DIR_DECRYPT, '1);
    program_key({32'hF0E1_D2C3, 32'hB4A5_9687, 32'h7869_5A4B, 32'h3C2D_1E0F,
                 32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210});
    push_block(DIR_ENCRYPT, 64'h1);
    push_block(DIR_ENCRYPT, 64'h8000_0000_0000_0000);
    push_block(DIR_DECRYPT, {32{2'b10}});
    push_block(DIR_DECRYPT, {32{2'b01}});

    for (int phase = 0; phase < 3; phase++) begin
      push_control(JOB_IDLE_RATE, (phase == 0) ? 22 : (phase == 1) ? 78 : 0);
      for (int i = 0; i < 8; i++)
        key_words[i] = (phase == 1 && i % 3 == 0) ? '0 : {$urandom};
      program_key(key_words);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
        bit_pos = $urandom_range(BLK_W - 1);
        case ($urandom_range(9))
          0:       blk = '0;
          1:       blk = '1;
          2:       blk = {{(BLK_W-1){1'b0}}, 1'b1} << bit_pos;
          3:       blk = ~({{(BLK_W-1){1'b0}}, 1'b1} << bit_pos);
          default: blk = {$urandom, $urandom};
        endcase
        push_block($urandom_range(1) ? DIR_DECRYPT : DIR_ENCRYPT, blk);
        if ($urandom_range(99) == 0)
          push_control(JOB_DRAIN, 0);
        if (n == RANDOM_ITEMS / 2) begin
          push_control(JOB_DRAIN, 0);
          push_key_write(IDX_W'($urandom_range(KEY_IDX_TOP, KEY_WORD_LAST + 1)),
                         {$urandom});
          push_key_write(KEY_WORD_0 + IDX_W'($urandom_range(KEY_WORD_LAST)), {$urandom});
        end
      end
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    do
      @(posedge clk);
    while (!jobs_finished || predicted_blocks.size() != 0);
    repeat (gbc_pkg::ROUNDS + 8) @(posedge clk);

    if (errors == 0 && predicted_blocks.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
